FILE: sv/dsc_pkg.sv
// ----------------------------------------------------------------------------
// dsc_pkg: shared types and constants for the dose schedule controller
// Request/response words, dose entry layout, mode and kind codes.
// ----------------------------------------------------------------------------
package dsc_pkg;

   localparam int DoseSlotsDefault  = 10;
   localparam int BoostLimitDefault = 3;

   localparam logic [5:0] TpsReset   = 6'd30;
   localparam logic [5:0] SecPerMin  = 6'd60;
   localparam logic [5:0] MinPerHr   = 6'd60;
   localparam logic [4:0] HrPerDay   = 5'd24;
   localparam logic [3:0] BoostCode  = 4'd11;

   localparam logic [2:0] MODE_TICK   = 3'd0;
   localparam logic [2:0] MODE_ADD    = 3'd1;
   localparam logic [2:0] MODE_EDIT   = 3'd2;
   localparam logic [2:0] MODE_REMOVE = 3'd3;
   localparam logic [2:0] MODE_CLEAR  = 3'd4;
   localparam logic [2:0] MODE_SETCLK = 3'd5;

   localparam logic [1:0] KIND_DOSE   = 2'd0;
   localparam logic [1:0] KIND_BOOST  = 2'd1;
   localparam logic [1:0] KIND_ACCEPT = 2'd2;
   localparam logic [1:0] KIND_REJECT = 2'd3;

   localparam logic CSR_TPS   = 1'b0;
   localparam logic CSR_BOOST = 1'b1;

   typedef struct packed {
      logic [2:0] mode;
      logic       paused;
      logic       boost_switch;
      logic       emergency_switch;
      logic [3:0] slot;
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
      logic       half_dose;
   } req_word_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [3:0] dose_number;
      logic       half_intensity;
      logic [4:0] clock_hour;
      logic [5:0] clock_minute;
      logic [5:0] clock_second;
      logic       stuck_flag;
      logic       halted_flag;
      logic       last;
   } rsp_word_type;

   // one schedule entry
   typedef struct packed {
      logic [4:0] hr;
      logic [5:0] mn;
      logic [5:0] sc;
      logic       done;
      logic       half;
   } dose_type;

   // control from sequencer to the cell row
   typedef struct packed {
      logic     shift;     // rotate row by one cell
      logic     load;      // cell 0 takes new_entry instead of the wrap entry
      logic     drop;      // cell 0 takes the entry after the wrap (compaction)
      logic     mark;      // set done on the entry rotating out
      dose_type new_entry;
   } row_ctl_type;

   function automatic logic time_ok(input logic [4:0] h, input logic [5:0] m,
                                    input logic [5:0] s);
      return (h < HrPerDay) && (m < MinPerHr) && (s < SecPerMin);
   endfunction

endpackage

FILE: sv/dsc_cell.sv
// ----------------------------------------------------------------------------
// dsc_cell: one schedule entry register of the rotating row
// Takes its neighbor's entry whenever the row shifts.
// ----------------------------------------------------------------------------
module dsc_cell import dsc_pkg::*; (
   input  logic     clock,
   input  logic     shift,
   input  dose_type prev_entry,
   output dose_type entry
);

   dose_type entry_ff;

   always_ff @(posedge clock) begin
      if (shift) begin
         entry_ff <= prev_entry;
      end
   end

   assign entry = entry_ff;

endmodule

FILE: sv/dsc_row.sv
// ----------------------------------------------------------------------------
// dsc_row: ring of dose cells
// Head cell feeds cell 0; loads, compaction and delivery marks act at the ring
// seam, so every entry passes the seam once per full rotation.
// ----------------------------------------------------------------------------
module dsc_row import dsc_pkg::*; #(
   parameter int DOSE_SLOTS = DoseSlotsDefault
) (
   input  logic        clock,
   input  row_ctl_type ctl,
   output dose_type    head,
   output dose_type    next_head
);

   dose_type cells [DOSE_SLOTS];
   dose_type feed  [DOSE_SLOTS];
   dose_type wrap;
   dose_type seam_entry;

   always_comb begin
      wrap = cells[DOSE_SLOTS-1];
      if (ctl.mark) begin
         wrap.done = 1'b1;
      end
      if (ctl.load) begin
         seam_entry = ctl.new_entry;
      end else if (ctl.drop) begin
         seam_entry = (DOSE_SLOTS > 1) ? cells[(DOSE_SLOTS > 1) ? DOSE_SLOTS-2 : 0] : wrap;
      end else begin
         seam_entry = wrap;
      end
   end

   for (genvar g = 0; g < DOSE_SLOTS; g++) begin : g_cell
      if (g == 0) begin : g_seam
         assign feed[g] = seam_entry;
      end else begin : g_feed
         assign feed[g] = cells[g-1];
      end
      dsc_cell u_cell (
         .clock      (clock),
         .shift      (ctl.shift),
         .prev_entry (feed[g]),
         .entry      (cells[g])
      );
   end

   assign head      = cells[DOSE_SLOTS-1];
   assign next_head = cells[(DOSE_SLOTS > 1) ? DOSE_SLOTS-2 : 0];

endmodule

FILE: sv/dose_schedule_controller.sv
// ----------------------------------------------------------------------------
// dose_schedule_controller: time-of-day dose scheduler with boost and halt
// Sequencer around a rotating ring of dose cells.
// ----------------------------------------------------------------------------
// Usage:
//   req_*: a command word is taken when start is high and busy is low.
//   rsp_*: results appear for one cycle each with rsp_valid; rsp_word.last
//     marks the final result of a command. The receiver cannot stall.
//   csr_*: register writes (0 ticks_per_second, 1 boost_half), taken on
//     csr_valid & csr_ready; ready always high, write only while idle.
// Flow (from one accepted word to the next accept):
//   Clear, set-clock and unknown commands, and ticks that do not service a
//   second, use only the command state; the result word is registered and
//   strobed once the block is idle again. Paused, halted or emergency ticks
//   also use only the command state and give no word. Add, edit and remove
//   rotate the ring once before the result word is strobed.
//   A serviced second walks the ring once comparing each head entry to the
//   clock (one cell per cycle), then checks the boost; a flush state follows
//   when a boost follows a delivered dose. A dose word is held until the next
//   hit or the boost check so the final one carries last.
// Reset: clock, tick count, dose count, boost and halt state cleared; the
//   ring itself is not cleared, only entries below the dose count are used.
// ----------------------------------------------------------------------------
module dose_schedule_controller import dsc_pkg::*; #(
   parameter int DOSE_SLOTS  = DoseSlotsDefault,
   parameter int BOOST_LIMIT = BoostLimitDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_word_type req_word,
   output logic         rsp_valid,
   output rsp_word_type rsp_word,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_index,
   input  logic [5:0]   csr_data
);

   localparam int CW = $clog2(DOSE_SLOTS + 1);
   localparam int BW = $clog2(BOOST_LIMIT + 1);
   localparam int SW = (CW > 4) ? CW : 4;    // width for slot vs count compare

   typedef enum logic [2:0] {S_IDLE, S_CMD, S_ROT, S_SCAN, S_BOOST, S_FLUSH} state_type;

   state_type    state_ff, state_in;
   req_word_type req_ff, req_in;
   logic [5:0]   tps_ff, tick_ff, tick_in;
   logic         bhalf_ff;
   logic [5:0]   sec_ff, min_ff, sec_in, min_in;
   logic [4:0]   hr_ff, hr_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] step_ff, step_in;   // ring position being passed at the seam
   logic [BW-1:0] boosts_ff, boosts_in;
   logic         down_ff, stuck_ff, halt_ff;
   logic         down_in, stuck_in, halt_in;
   logic         ok_ff, ok_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_ff, rsp_in;
   logic         pend_valid_ff, pend_valid_in;   // dose word held back one hit
   rsp_word_type pend_ff, pend_in;

   row_ctl_type ctl;
   dose_type    head, next_head;
   logic [CW-1:0] rot_pos;     // index of entry at head this cycle
   logic [CW-1:0] slot_pos;
   logic        at_slot;
   logic        target_done;
   logic        hit;
   logic        bfire;
   logic [5:0]  tps_eff;
   logic [5:0]  tick_inc;
   rsp_word_type status;
   rsp_word_type bword;

   dsc_row #(.DOSE_SLOTS(DOSE_SLOTS)) u_row (
      .clock     (clock),
      .ctl       (ctl),
      .head      (head),
      .next_head (next_head)
   );

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   assign tps_eff  = (tps_ff == 6'd0) ? 6'd1 : tps_ff;
   assign tick_inc = tick_ff + 6'd1;
   // At the home alignment head holds entry 0 and the cell feeding it entry 1;
   // after k shifts head holds entry k. Every rotation starts at home and
   // ends there after DOSE_SLOTS shifts, so the step count is the index.
   assign rot_pos  = step_ff;
   assign slot_pos = CW'(req_ff.slot);
   assign at_slot  = (rot_pos == slot_pos);
   // edit and remove refuse an entry that was already delivered
   assign target_done = ok_ff && (req_ff.mode != MODE_ADD) && at_slot && head.done;
   assign hit = (rot_pos < count_ff) && (head.hr == hr_ff) && (head.mn == min_ff)
                && (head.sc == sec_ff);

   // Remove: from the slot on, each entry is replaced by its successor, so
   // cell 0 takes next_head instead of head.
   always_comb begin
      ctl = '0;
      ctl.new_entry = '{hr: req_ff.hour, mn: req_ff.minute, sc: req_ff.second,
                        done: 1'b0, half: req_ff.half_dose};
      if (state_ff == S_ROT) begin
         ctl.shift = 1'b1;
         case (req_ff.mode)
            MODE_ADD:    ctl.load = ok_ff && (rot_pos == count_ff);
            MODE_EDIT:   ctl.load = ok_ff && at_slot && !head.done;
            MODE_REMOVE: ctl.drop = ok_ff && (rot_pos >= slot_pos) && !target_done;
            default:     ctl.load = 1'b0;
         endcase
      end else if (state_ff == S_SCAN) begin
         ctl.shift = 1'b1;
         ctl.mark  = hit;
      end
   end

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      tick_in       = tick_ff;
      sec_in        = sec_ff;
      min_in        = min_ff;
      hr_in         = hr_ff;
      count_in      = count_ff;
      step_in       = step_ff;
      boosts_in     = boosts_ff;
      down_in       = down_ff;
      stuck_in      = stuck_ff;
      halt_in       = halt_ff;
      ok_in         = ok_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      bfire         = 1'b0;
      // command status word with the current clock and flags
      status = '{kind: KIND_REJECT, dose_number: 4'd0, half_intensity: 1'b0,
                 clock_hour: hr_ff, clock_minute: min_ff, clock_second: sec_ff,
                 stuck_flag: stuck_ff, halted_flag: halt_ff, last: 1'b1};
      bword  = '{kind: KIND_BOOST, dose_number: BoostCode, half_intensity: bhalf_ff,
                 clock_hour: hr_ff, clock_minute: min_ff, clock_second: sec_ff,
                 stuck_flag: 1'b0, halted_flag: halt_ff, last: 1'b1};
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in   = req_word;
               step_in  = '0;
               state_in = S_CMD;
            end
         end
         S_CMD: begin
            state_in = S_IDLE;
            case (req_ff.mode)
               MODE_TICK: begin
                  if (tick_inc >= tps_eff) begin
                     tick_in = '0;
                     if (sec_ff + 6'd1 >= SecPerMin) begin
                        sec_in = '0;
                        if (min_ff + 6'd1 >= MinPerHr) begin
                           min_in = '0;
                           hr_in  = (hr_ff + 5'd1 >= HrPerDay) ? 5'd0 : hr_ff + 5'd1;
                        end else begin
                           min_in = min_ff + 6'd1;
                        end
                     end else begin
                        sec_in = sec_ff + 6'd1;
                     end
                     if (req_ff.emergency_switch) begin
                        halt_in = 1'b1;
                     end
                     if (!req_ff.paused && !req_ff.emergency_switch && !halt_ff) begin
                        state_in = S_SCAN;
                     end
                  end else begin
                     tick_in = tick_inc;
                  end
               end
               MODE_ADD: begin
                  ok_in    = (count_ff < CW'(DOSE_SLOTS)) &&
                             time_ok(req_ff.hour, req_ff.minute, req_ff.second);
                  state_in = S_ROT;
               end
               MODE_EDIT, MODE_REMOVE: begin
                  ok_in    = (SW'(req_ff.slot) < SW'(count_ff)) &&
                             ((req_ff.mode == MODE_REMOVE) ||
                              time_ok(req_ff.hour, req_ff.minute, req_ff.second));
                  state_in = S_ROT;
               end
               MODE_CLEAR: begin
                  count_in     = '0;
                  boosts_in    = '0;
                  rsp_valid_in = 1'b1;
                  rsp_in       = status;
                  rsp_in.kind  = KIND_ACCEPT;
               end
               MODE_SETCLK: begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = status;
                  if (time_ok(req_ff.hour, req_ff.minute, req_ff.second)) begin
                     hr_in  = req_ff.hour;
                     min_in = req_ff.minute;
                     sec_in = req_ff.second;
                     rsp_in.kind         = KIND_ACCEPT;
                     rsp_in.clock_hour   = req_ff.hour;
                     rsp_in.clock_minute = req_ff.minute;
                     rsp_in.clock_second = req_ff.second;
                  end
               end
               default: begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = status;
               end
            endcase
         end
         S_ROT: begin
            step_in = step_ff + CW'(1);
            if (target_done) begin
               ok_in = 1'b0;
            end
            if (step_ff == CW'(DOSE_SLOTS - 1)) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               rsp_in       = status;
               if (ok_ff && !target_done) begin
                  if (req_ff.mode == MODE_ADD) begin
                     count_in = count_ff + CW'(1);
                  end else if (req_ff.mode == MODE_REMOVE) begin
                     count_in = count_ff - CW'(1);
                  end
                  rsp_in.kind = KIND_ACCEPT;
               end
            end
         end
         S_SCAN: begin
            step_in = step_ff + CW'(1);
            if (hit) begin
               rsp_valid_in   = pend_valid_ff;
               rsp_in         = pend_ff;
               pend_valid_in  = 1'b1;
               pend_in        = status;
               pend_in.kind   = KIND_DOSE;
               pend_in.dose_number    = 4'(step_ff) + 4'd1;
               pend_in.half_intensity = head.half;
               pend_in.last   = 1'b0;
            end
            if (step_ff == CW'(DOSE_SLOTS - 1)) begin
               state_in = S_BOOST;
            end
         end
         S_BOOST: begin
            state_in = S_IDLE;
            if (!req_ff.boost_switch) begin
               down_in  = 1'b0;
               stuck_in = 1'b0;
            end else begin
               down_in = 1'b1;
               if (down_ff) begin
                  stuck_in = 1'b1;
               end
               bfire = !down_ff && !stuck_ff && (boosts_ff < BW'(BOOST_LIMIT));
            end
            if (bfire) begin
               boosts_in = boosts_ff + BW'(1);
            end
            if (pend_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_in       = pend_ff;
               rsp_in.last  = !bfire;
               if (bfire) begin
                  pend_in  = bword;
                  state_in = S_FLUSH;
               end else begin
                  pend_valid_in = 1'b0;
               end
            end else if (bfire) begin
               rsp_valid_in = 1'b1;
               rsp_in       = bword;
            end
         end
         S_FLUSH: begin
            state_in      = S_IDLE;
            rsp_valid_in  = 1'b1;
            rsp_in        = pend_ff;
            pend_valid_in = 1'b0;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      rsp_ff  <= rsp_in;
      pend_ff <= pend_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         tps_ff        <= TpsReset;
         bhalf_ff      <= 1'b0;
         tick_ff       <= '0;
         sec_ff        <= '0;
         min_ff        <= '0;
         hr_ff         <= '0;
         count_ff      <= '0;
         boosts_ff     <= '0;
         down_ff       <= 1'b0;
         stuck_ff      <= 1'b0;
         halt_ff       <= 1'b0;
         step_ff       <= '0;
         ok_ff         <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
         tick_ff       <= tick_in;
         sec_ff        <= sec_in;
         min_ff        <= min_in;
         hr_ff         <= hr_in;
         count_ff      <= count_in;
         boosts_ff     <= boosts_in;
         down_ff       <= down_in;
         stuck_ff      <= stuck_in;
         halt_ff       <= halt_in;
         step_ff       <= step_in;
         ok_ff         <= ok_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_TPS) begin
               tps_ff <= csr_data;
            end else begin
               bhalf_ff <= csr_data[0];
            end
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> busy || $past(busy))
      else $error("result outside a command");
   assert property (@(posedge clock) disable iff (reset) count_ff <= CW'(DOSE_SLOTS))
      else $error("dose count overflow");
   assert property (@(posedge clock) disable iff (reset) boosts_ff <= BW'(BOOST_LIMIT))
      else $error("boost count overflow");

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the dose schedule controller
// Drives command words through start/busy, predicts every result word from a
// behavioral copy of the schedule, clock and boost logic, and compares each
// rsp word against the oldest expected one. Registers are changed between
// phases while the block is idle.
// ----------------------------------------------------------------------------
module tb import dsc_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS       = DoseSlotsDefault;
   localparam int BOOST_MAX   = BoostLimitDefault;
   localparam int LIMIT_CYCLE = 400000;

   logic         clock;
   logic         reset;
   logic         start = 1'b0;
   logic         busy;
   req_word_type req_word = '0;
   logic         rsp_valid;
   rsp_word_type rsp_word;
   logic         csr_valid;
   logic         csr_ready;
   logic         csr_index;
   logic [5:0]   csr_data;

   dose_schedule_controller u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_word(req_word), .rsp_valid(rsp_valid), .rsp_word(rsp_word),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---- predictor state: a mirror of the block's clock, schedule, boosts
   logic [5:0] tps_reg = TpsReset;
   logic       boost_half_reg = 1'b0;
   logic [5:0] tick_cnt = '0;
   logic [5:0] now_sec = '0;
   logic [5:0] now_min = '0;
   logic [4:0] now_hr = '0;
   int         n_doses = 0;
   dose_type   sched [SLOTS];
   int         boosts_given = 0;
   logic       sw_held = 1'b0;
   logic       stuck = 1'b0;
   logic       halt = 1'b0;

   rsp_word_type expected_rsp [$];
   req_word_type pending_cmd [$];
   int           errors = 0;
   int           cycle = 0;

   function automatic bit valid_time(logic [4:0] h, logic [5:0] m, logic [5:0] s);
      return h <= 23 && m <= 59 && s <= 59;
   endfunction

   function automatic rsp_word_type result_word(logic [1:0] k, logic [3:0] num,
                                                logic hf);
      rsp_word_type r;
      r.kind = k;
      r.dose_number = num;
      r.half_intensity = hf;
      r.clock_hour = now_hr;
      r.clock_minute = now_min;
      r.clock_second = now_sec;
      r.stuck_flag = stuck;
      r.halted_flag = halt;
      r.last = 1'b0;
      return r;
   endfunction

   // apply one accepted word to the mirror, queue what it should produce
   task automatic predict_word(req_word_type w);
      rsp_word_type outs [$];
      rsp_word_type r;
      logic [5:0]   lim;
      bit           ok;
      ok = 0;
      if (w.mode == MODE_TICK) begin
         lim = (tps_reg == 0) ? 6'd1 : tps_reg;
         tick_cnt = tick_cnt + 6'd1;
         if (tick_cnt >= lim) begin
            tick_cnt = '0;
            now_sec++;
            if (now_sec >= 60) begin
               now_sec = '0;
               now_min++;
               if (now_min >= 60) begin
                  now_min = '0;
                  now_hr++;
                  if (now_hr >= 24) now_hr = '0;
               end
            end
            if (w.emergency_switch) halt = 1'b1;
            if (!w.paused && !halt) begin
               for (int i = 0; i < n_doses; i++) begin
                  if (sched[i].hr == now_hr && sched[i].mn == now_min &&
                      sched[i].sc == now_sec) begin
                     sched[i].done = 1'b1;
                     outs.push_back(result_word(KIND_DOSE, 4'(i + 1), sched[i].half));
                  end
               end
               if (!w.boost_switch) begin
                  sw_held = 1'b0;
                  stuck = 1'b0;
               end else begin
                  if (sw_held) stuck = 1'b1;
                  if (boosts_given < BOOST_MAX && !stuck) begin
                     boosts_given++;
                     outs.push_back(result_word(KIND_BOOST, BoostCode,
                                                boost_half_reg));
                  end
                  sw_held = 1'b1;
               end
            end
         end
      end else begin
         case (w.mode)
            MODE_ADD: if (n_doses < SLOTS && valid_time(w.hour, w.minute, w.second)) begin
               sched[n_doses] = '{w.hour, w.minute, w.second, 1'b0, w.half_dose};
               n_doses++;
               ok = 1;
            end
            MODE_EDIT: if (w.slot < n_doses && !sched[w.slot].done &&
                           valid_time(w.hour, w.minute, w.second)) begin
               sched[w.slot] = '{w.hour, w.minute, w.second, 1'b0, w.half_dose};
               ok = 1;
            end
            MODE_REMOVE: if (w.slot < n_doses && !sched[w.slot].done) begin
               for (int i = w.slot; i + 1 < n_doses; i++) sched[i] = sched[i + 1];
               n_doses--;
               ok = 1;
            end
            MODE_CLEAR: begin
               n_doses = 0;
               boosts_given = 0;
               ok = 1;
            end
            MODE_SETCLK: if (valid_time(w.hour, w.minute, w.second)) begin
               now_hr = w.hour;
               now_min = w.minute;
               now_sec = w.second;
               ok = 1;
            end
            default: ok = 0;
         endcase
         outs.push_back(result_word(ok ? KIND_ACCEPT : KIND_REJECT, 4'd0, 1'b0));
      end
      if (outs.size() > 0) outs[outs.size() - 1].last = 1'b1;
      foreach (outs[j]) expected_rsp.push_back(outs[j]);
   endtask

   task automatic report_mismatch(string what, rsp_word_type got, rsp_word_type want);
      $display("ERROR cycle %0d: %s got %h want %h", cycle, what, got, want);
      errors++;
   endtask

   // ---- driver: pops pending words, random gap before each
   int  gap_left;
   bit  drv_enable;

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         gap_left <= 0;
      end else if (start && !busy) begin
         // word taken at this edge
         predict_word(req_word);
         void'(pending_cmd.pop_front());
         start <= 1'b0;
         gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
      end else if (!start && drv_enable && pending_cmd.size() > 0) begin
         if (gap_left > 0) gap_left <= gap_left - 1;
         else begin
            req_word <= pending_cmd[0];
            start <= 1'b1;
         end
      end
   end

   // ---- monitor: every strobed result word is checked in order
   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (!reset && rsp_valid) begin
         if (expected_rsp.size() == 0) begin
            report_mismatch("unexpected word", rsp_word, '0);
         end else begin
            rsp_word_type e;
            e = expected_rsp.pop_front();
            if (rsp_word !== e) report_mismatch("result word", rsp_word, e);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (cycle > LIMIT_CYCLE) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // ---- stimulus helpers
   function automatic req_word_type cmd(logic [2:0] md);
      req_word_type w;
      w = req_word_type'($urandom);   // junk in unused fields
      w.mode = md;
      return w;
   endfunction

   function automatic req_word_type timed(logic [2:0] md, logic [4:0] h, logic [5:0] m,
                                          logic [5:0] s, logic hf);
      req_word_type w;
      w = cmd(md);
      w.hour = h;
      w.minute = m;
      w.second = s;
      w.half_dose = hf;
      return w;
   endfunction

   function automatic req_word_type tick(logic p, logic b, logic em);
      req_word_type w;
      w = cmd(MODE_TICK);
      w.paused = p;
      w.boost_switch = b;
      w.emergency_switch = em;
      return w;
   endfunction

   function automatic req_word_type rand_time_cmd(logic [2:0] md);
      req_word_type w;
      w = cmd(md);
      if ($urandom_range(0, 9) != 0) begin
         w.hour = 5'($urandom_range(0, 23));
         w.minute = 6'($urandom_range(0, 59));
         w.second = 6'($urandom_range(0, 59));
      end
      return w;
   endfunction

   // wait until all queued words are taken and all results are back
   task automatic drain();
      while (pending_cmd.size() > 0 || start || expected_rsp.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);  // a tick may still be walking the ring
   endtask

   task automatic csr_write(logic idx, logic [5:0] val);
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_TPS) tps_reg = val;
      else boost_half_reg = val[0];
   endtask

   // one random phase: mostly ticks plus schedule work near the clock
   task automatic random_phase(int count, bit allow_halt);
      req_word_type w;
      int r;
      for (int k = 0; k < count; k++) begin
         r = $urandom_range(0, 99);
         if (r < 55) begin
            w = tick($urandom_range(0, 7) == 0, 1'($urandom_range(0, 1)),
                     allow_halt && $urandom_range(0, 150) == 0);
         end else if (r < 70) begin
            // add a dose a few seconds ahead so it really fires
            w = timed(MODE_ADD, now_hr, now_min,
                      6'(($urandom_range(1, 4) + now_sec) % 60),
                      1'($urandom_range(0, 1)));
            if ($urandom_range(0, 7) == 0) w = rand_time_cmd(MODE_ADD);
         end else if (r < 78) begin
            w = rand_time_cmd(MODE_EDIT);
            w.slot = 4'($urandom_range(0, 15));
         end else if (r < 86) begin
            w = cmd(MODE_REMOVE);
            w.slot = 4'($urandom_range(0, 15));
         end else if (r < 90) begin
            w = cmd(MODE_CLEAR);
         end else if (r < 96) begin
            w = rand_time_cmd(MODE_SETCLK);
         end else begin
            w = cmd(3'($urandom_range(6, 7)));
         end
         pending_cmd.push_back(w);
         // predictor state moves only on acceptance, so feed one at a time
         while (pending_cmd.size() > 0) @(posedge clock);
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_index = CSR_TPS;
      csr_data = '0;
      drv_enable = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: one tick per second to keep it short, extremes of time fields
      csr_write(CSR_TPS, 6'd1);
      csr_write(CSR_BOOST, 6'd1);
      drv_enable = 1'b1;
      pending_cmd.push_back(timed(MODE_SETCLK, 5'd23, 6'd59, 6'd58, 1'b0));
      pending_cmd.push_back(timed(MODE_ADD, 5'd23, 6'd59, 6'd59, 1'b1));
      pending_cmd.push_back(timed(MODE_ADD, 5'd0, 6'd0, 6'd0, 1'b0));
      pending_cmd.push_back(timed(MODE_ADD, 5'd24, 6'd0, 6'd0, 1'b0));   // bad hour
      pending_cmd.push_back(timed(MODE_ADD, 5'd0, 6'd63, 6'd0, 1'b0));   // bad minute
      pending_cmd.push_back(timed(MODE_SETCLK, 5'd31, 6'd0, 6'd60, 1'b0));
      pending_cmd.push_back(tick(1'b0, 1'b1, 1'b0));   // dose 1 plus boost
      pending_cmd.push_back(tick(1'b0, 1'b1, 1'b0));   // wrap to midnight, held switch
      pending_cmd.push_back(tick(1'b0, 1'b0, 1'b0));   // release
      pending_cmd.push_back(timed(MODE_EDIT, 5'd1, 6'd2, 6'd3, 1'b0)); // slot junk
      begin
         req_word_type w;
         w = timed(MODE_EDIT, 5'd1, 6'd1, 6'd1, 1'b1);
         w.slot = 4'd0;                                // delivered: rejected
         pending_cmd.push_back(w);
         w = cmd(MODE_REMOVE);
         w.slot = 4'd15;
         pending_cmd.push_back(w);
         w = cmd(MODE_REMOVE);
         w.slot = 4'd1;                                // delivered too
         pending_cmd.push_back(w);
      end
      pending_cmd.push_back(cmd(MODE_CLEAR));
      pending_cmd.push_back(cmd(3'd6));
      pending_cmd.push_back(cmd(3'd7));
      for (int i = 0; i < SLOTS + 1; i++)              // fill past full
         pending_cmd.push_back(timed(MODE_ADD, 5'd0, 6'd0, 6'd3, i[0]));
      pending_cmd.push_back(tick(1'b1, 1'b1, 1'b0));   // paused
      pending_cmd.push_back(tick(1'b0, 1'b1, 1'b0));   // all ten fire plus boost
      drv_enable = 1'b0;
      // predictor runs at acceptance; release words one at a time
      begin
         req_word_type hold [$];
         hold = pending_cmd;
         pending_cmd.delete();
         drv_enable = 1'b1;
         foreach (hold[i]) begin
            pending_cmd.push_back(hold[i]);
            while (pending_cmd.size() > 0) @(posedge clock);
         end
      end
      drain();

      // random phases over several register settings
      csr_write(CSR_TPS, 6'd0);
      csr_write(CSR_BOOST, 6'd0);
      random_phase(120, 1'b0);
      drain();
      csr_write(CSR_TPS, 6'd2);
      random_phase(120, 1'b0);
      drain();
      csr_write(CSR_TPS, 6'd63);
      csr_write(CSR_BOOST, 6'd1);
      random_phase(60, 1'b0);
      drain();
      csr_write(CSR_TPS, 6'd1);
      random_phase(110, 1'b1);
      pending_cmd.push_back(tick(1'b0, 1'b1, 1'b1));   // emergency halts for good
      while (pending_cmd.size() > 0) @(posedge clock);
      random_phase(20, 1'b1);
      drain();

      if (errors == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
